>>> rtl/mmva_pkg.sv
package mmva_pkg;

    localparam int ROW_W     = 8;
    localparam int COL_W     = 12;
    localparam int VAL_W     = 17;
    localparam int MODULUS_W = 17;
    localparam int Q_DEPTH   = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [MODULUS_W-1:0] MODULUS_RESET = 17'd12289;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_MAC  = 1'b1
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               col_ok;
        logic               row_ok;
        logic [VAL_W-1:0]   value;
        logic               first_pass;
        logic               row_end;
    } mmva_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_RED,
        BK_DONE
    } back_state_t;

endpackage

>>> rtl/mmva_ram.sv
module mmva_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mmva_front.sv
module mmva_front
    import mmva_pkg::*;
#(
    parameter int ROWS = 256,
    parameter int COLS = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 cmd_valid,
    output mmva_cmd_t            cmd,
    input  logic                 cmd_pop
);

    localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    mmva_cmd_t        q_mem_reg [Q_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QA_W:0]    count_reg, count_next;
    mmva_cmd_t        in_cmd;
    logic             push;

    always_comb begin
        in_cmd.action     = action_t'(s_axis_tuser);
        in_cmd.row        = s_axis_tdata[ROW_W-1:0];
        in_cmd.col        = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
        in_cmd.value      = s_axis_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
        in_cmd.first_pass = s_axis_tdata[ROW_W+COL_W+VAL_W];
        in_cmd.row_end    = s_axis_tlast;
        in_cmd.col_ok     = (32'(in_cmd.col) < COLS);
        in_cmd.row_ok     = (32'(in_cmd.row) < ROWS);
    end

    assign s_axis_tready = (count_reg != (QA_W+1)'(Q_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (count_reg != '0);
    assign cmd           = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && cmd_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> rtl/mmva_back.sv
module mmva_back
    import mmva_pkg::*;
#(
    parameter int ROWS     = 256,
    parameter int COLS     = 4096,
    parameter int MOD_BITS = 17
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [MODULUS_W-1:0] modulus,
    input  logic                 cmd_valid,
    input  mmva_cmd_t            cmd,
    output logic                 cmd_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PROD_W = VAL_W + MOD_BITS;
    localparam int X_RAW  = PROD_W + 1;
    localparam int XE     = X_RAW + (X_RAW % 2);
    localparam int STEPS  = XE / 2;
    localparam int CNT_W  = $clog2(STEPS);

    back_state_t           state_reg, state_next;
    mmva_cmd_t             cmd_reg;
    logic [XE-1:0]         x_reg;
    logic [MOD_BITS-1:0]   xlo_reg;
    logic [MODULUS_W-1:0]  rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [MOD_BITS-1:0]   run_sum_reg;
    logic                  row_open_reg;
    logic                  m_valid_reg;
    logic [ROW_W-1:0]      m_row_reg;
    logic [VAL_W-1:0]      m_residue_reg;

    logic                  vec_we;
    logic [COL_AW-1:0]     vec_waddr, vec_raddr;
    logic [MOD_BITS-1:0]   vec_wdata, vec_rdata;
    logic                  res_we;
    logic [ROW_AW-1:0]     res_waddr, res_raddr;
    logic [MOD_BITS-1:0]   res_rdata;

    logic                  out_free;
    logic                  done_go;
    logic                  red_last;
    logic [MOD_BITS-1:0]   vec_op;
    logic [MOD_BITS-1:0]   base;
    logic [PROD_W-1:0]     prod;
    logic [XE-1:0]         x_next;
    logic [MODULUS_W:0]    r1, r2;
    logic [MODULUS_W-1:0]  rem_next;
    logic [MOD_BITS-1:0]   sum;

    mmva_ram #(.WIDTH(MOD_BITS), .DEPTH(COLS)) u_vec_ram (
        .aclk    (aclk),
        .wr_en   (vec_we),
        .wr_addr (vec_waddr),
        .wr_data (vec_wdata),
        .rd_addr (vec_raddr),
        .rd_data (vec_rdata)
    );

    mmva_ram #(.WIDTH(MOD_BITS), .DEPTH(ROWS)) u_res_ram (
        .aclk    (aclk),
        .wr_en   (res_we),
        .wr_addr (res_waddr),
        .wr_data (sum),
        .rd_addr (res_raddr),
        .rd_data (res_rdata)
    );

    assign out_free = !m_valid_reg || m_axis_tready;
    assign done_go  = !cmd_reg.row_end || out_free;
    assign red_last = (cnt_reg == CNT_W'(STEPS-1));

    // Start value and multiply-add, taken from the memory reads issued at pop.
    always_comb begin
        vec_op = cmd_reg.col_ok ? vec_rdata : '0;
        if (row_open_reg) begin
            base = run_sum_reg;
        end else if (cmd_reg.first_pass || !cmd_reg.row_ok) begin
            base = '0;
        end else begin
            base = res_rdata;
        end
        prod   = cmd_reg.value * vec_op;
        x_next = XE'(prod) + XE'(base);
    end

    // Two restoring remainder steps per cycle, most significant bits first.
    always_comb begin
        r1 = {rem_reg, x_reg[XE-1]};
        if (r1 >= {1'b0, modulus}) begin
            r1 = r1 - {1'b0, modulus};
        end
        r2 = {r1[MODULUS_W-1:0], x_reg[XE-2]};
        if (r2 >= {1'b0, modulus}) begin
            r2 = r2 - {1'b0, modulus};
        end
        rem_next = r2[MODULUS_W-1:0];
    end

    assign sum = (modulus == '0) ? xlo_reg : MOD_BITS'(rem_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && (cmd.action == ACT_MAC)) begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL: begin
                state_next = BK_RED;
            end
            BK_RED: begin
                if (red_last) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (done_go) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_pop   = 1'b0;
        vec_we    = 1'b0;
        res_we    = 1'b0;
        vec_waddr = COL_AW'(cmd.col);
        vec_wdata = MOD_BITS'(cmd.value);
        vec_raddr = COL_AW'(cmd.col);
        res_raddr = ROW_AW'(cmd.row);
        res_waddr = ROW_AW'(cmd_reg.row);
        unique case (state_reg)
            BK_IDLE: begin
                cmd_pop = cmd_valid;
                vec_we  = cmd_valid && (cmd.action == ACT_LOAD) && cmd.col_ok;
            end
            BK_DONE: begin
                res_we = done_go && cmd_reg.row_end && cmd_reg.row_ok;
            end
            default: begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            run_sum_reg  <= '0;
            row_open_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_DONE && done_go) begin
                run_sum_reg  <= sum;
                row_open_reg <= !cmd_reg.row_end;
            end
            if (state_reg == BK_DONE && done_go && cmd_reg.row_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_IDLE && cmd_valid) begin
            cmd_reg <= cmd;
        end
        if (state_reg == BK_MUL) begin
            x_reg   <= x_next;
            xlo_reg <= MOD_BITS'(x_next);
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (state_reg == BK_RED) begin
            x_reg   <= x_reg << 2;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == BK_DONE && done_go && cmd_reg.row_end) begin
            m_row_reg     <= cmd_reg.row;
            m_residue_reg <= VAL_W'(sum);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-ROW_W-VAL_W){1'b0}}, m_residue_reg, m_row_reg};

endmodule

>>> rtl/modular_matvec_accumulate.sv
// Modular matrix-vector multiply-accumulate over Z_q.
// Input stream (s_axis): tuser selects a vector load (0) or a matrix element (1);
// tlast marks the last matrix element of a row. Vector elements are loaded first,
// then matrix elements stream in row-major order.
// Result stream (m_axis): one transfer per row end, carrying the row and its residue.
// The modulus is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A vector load is written to the vector store as it is popped. A matrix element
// goes through issuing the memory reads, the multiply-add, the remainder unit that
// retires two bits per cycle, and write back, which at a row end fills the output register.
// A two-entry queue sits between the input side and the execution unit, so input
// transfers are taken while an element is being worked on.
// When the receiver stalls, the result waits in the output register and the
// execution unit holds the next row end until that register empties.
// After reset the modulus is 12289, no row is open and the running sum is zero;
// the vector and residue stores hold nothing valid until written.
module modular_matvec_accumulate
    import mmva_pkg::*;
#(
    parameter int ROWS     = 256,
    parameter int COLS     = 4096,
    parameter int MOD_BITS = 17
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [MODULUS_W-1:0] cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: row[7:0], col[19:8], value[36:20], first_pass[37], zero[39:38].
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Field: action[0].
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: out_row[7:0], residue[24:8], zero[31:25].
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [MODULUS_W-1:0] modulus_reg;
    logic                 cmd_valid;
    logic                 cmd_pop;
    mmva_cmd_t            cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
    end

    mmva_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    mmva_back #(.ROWS(ROWS), .COLS(COLS), .MOD_BITS(MOD_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .modulus       (modulus_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
